FILE: design/tcw_pkg.sv
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: the payload
// structs of both channels, the command passed from front to back, and the
// character codes that the console interprets.
// ---------------------------------------------------------------------------
package tcw_pkg;

  typedef struct packed {
    logic        mode;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [10:0] cursor_linear;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic [15:0] cell_data;
  } out_item_t;

  localparam logic       MODE_PUT     = 1'b0;
  localparam logic       MODE_READ    = 1'b1;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_BACKSPACE,
    CMD_TAB,
    CMD_CR,
    CMD_LF,
    CMD_IGNORE,
    CMD_READ,
    CMD_READ_OOR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } cmd_t;

  // Status from the queue and back end, seen by the front end
  typedef struct packed {
    logic queue_full;
    logic clearing;
  } front_ctl_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } queue_stat_t;

endpackage

FILE: design/tcw_front.sv
// ---------------------------------------------------------------------------
// tcw_front
// Accepts input items and classifies each into a console command.
// ---------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tcw_pkg::in_item_t    in_item,
  input  tcw_pkg::front_ctl_t  ctl,
  output logic                 push,
  output tcw_pkg::cmd_t        push_cmd
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  cmd_kind_t kind;

  // hold off while the screen is being cleared or the queue is full
  assign in_stall = ctl.queue_full | ctl.clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    if (in_item.mode == MODE_READ) begin
      kind = (32'(in_item.cell_index) < CELLS) ? CMD_READ : CMD_READ_OOR;
    end else begin
      priority if (in_item.char_code == CH_BACKSPACE) kind = CMD_BACKSPACE;
      else if (in_item.char_code == CH_TAB)           kind = CMD_TAB;
      else if (in_item.char_code == CH_CR)            kind = CMD_CR;
      else if (in_item.char_code == CH_LF)            kind = CMD_LF;
      else if (in_item.char_code >= CH_SPACE)         kind = CMD_PRINT;
      else                                            kind = CMD_IGNORE;
    end
  end

  assign push_cmd.kind       = kind;
  assign push_cmd.char_code  = in_item.char_code;
  assign push_cmd.cell_index = in_item.cell_index;

endmodule

FILE: design/tcw_queue.sv
// ---------------------------------------------------------------------------
// tcw_queue
// Two-entry command queue between the front and back ends.
// ---------------------------------------------------------------------------
module tcw_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  tcw_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output logic                  full,
  output tcw_pkg::queue_stat_t  stat
);
  import tcw_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign stat.head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/tcw_back.sv
// ---------------------------------------------------------------------------
// tcw_back
// Executes console commands: holds the screen memory, the cursor and the
// attribute, runs the clear, scroll and fill sweeps and issues results.
// ---------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_data,
  input  tcw_pkg::queue_stat_t  qstat,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tcw_pkg::out_item_t    out_item
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CCW   = $clog2(COLUMNS);
  localparam int CW    = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int TW    = $clog2(TAB_STOP);

  localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END    = AW'(CELLS - COLUMNS);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [CW-1:0] COL_LIMIT   = CW'(COLUMNS);
  localparam logic [CW-1:0] TAB_W       = CW'(TAB_STOP);
  localparam logic [TW-1:0] PHASE_LAST  = TW'(TAB_STOP - 1);
  localparam logic [RW-1:0] ROW_LAST    = RW'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCROLL = 5'b00100,
    ST_FILL   = 5'b01000,
    ST_RESP   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   seq_r, seq_nxt;
  logic [CCW-1:0]  col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [TW-1:0]   phase_r, phase_nxt;
  logic [7:0]      attr_r;
  logic            resp_read_r, resp_read_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  logic [15:0]     mem [CELLS];
  logic [15:0]     rdata_r;
  logic            we, re;
  logic [AW-1:0]   wa, ra;
  logic [15:0]     wd;

  cmd_t            cmd;
  logic [CW-1:0]   col_w;
  logic [TW-1:0]   phase_w;
  logic            row_inc;
  logic            out_free;
  logic [15:0]     blank;

  assign cmd       = qstat.head;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign blank     = {attr_r, CH_SPACE};
  assign clearing  = (state_r == ST_CLEAR);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // cursor update for a put command at the queue head
  always_comb begin
    col_w   = CW'(col_r);
    phase_w = phase_r;
    row_inc = 1'b0;
    unique case (cmd.kind)
      CMD_PRINT: begin
        col_w   = CW'(col_r) + CW'(1);
        phase_w = (phase_r == PHASE_LAST) ? '0 : phase_r + TW'(1);
      end
      CMD_BACKSPACE: begin
        if (col_r != '0) begin
          col_w   = CW'(col_r) - CW'(1);
          phase_w = (phase_r == '0) ? PHASE_LAST : phase_r - TW'(1);
        end
      end
      CMD_TAB: begin
        col_w   = CW'(col_r) + TAB_W - CW'(phase_r);
        phase_w = '0;
      end
      CMD_CR: begin
        col_w   = '0;
        phase_w = '0;
      end
      CMD_LF: begin
        col_w   = '0;
        phase_w = '0;
        row_inc = 1'b1;
      end
      default: ;
    endcase
    // wrap past the last column
    if (col_w >= COL_LIMIT) begin
      col_w   = '0;
      phase_w = '0;
      row_inc = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    phase_nxt     = phase_r;
    resp_read_nxt = resp_read_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    we            = 1'b0;
    wa            = seq_r;
    wd            = '0;
    re            = 1'b0;
    ra            = AW'(cmd.cell_index);

    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1;
        if (seq_r == LAST_CELL) begin
          seq_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          seq_nxt = seq_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop           = 1'b1;
          resp_read_nxt = (cmd.kind == CMD_READ);
          state_nxt     = ST_RESP;
          if (cmd.kind == CMD_READ) begin
            re = 1'b1;
          end else if (cmd.kind != CMD_READ_OOR) begin
            if (cmd.kind == CMD_PRINT) begin
              we = 1'b1;
              wa = base_r + AW'(col_r);
              wd = {attr_r, cmd.char_code};
            end else if (cmd.kind == CMD_BACKSPACE) begin
              we = 1'b1;
              wa = base_r + AW'(col_w);
              wd = blank;
            end
            col_nxt   = CCW'(col_w);
            phase_nxt = phase_w;
            if (row_inc) begin
              if (row_r == ROW_LAST) begin
                seq_nxt   = '0;
                state_nxt = ST_SCROLL;
              end else begin
                row_nxt  = row_r + RW'(1);
                base_nxt = base_r + ROW_STEP;
              end
            end
          end
        end
      end
      ST_SCROLL: begin
        // read one row below, write the previous read one place behind
        if (seq_r != COPY_END) begin
          re = 1'b1;
          ra = seq_r + ROW_STEP;
        end
        if (seq_r != '0) begin
          we = 1'b1;
          wa = seq_r - AW'(1);
          wd = rdata_r;
        end
        if (seq_r == COPY_END) begin
          state_nxt = ST_FILL;
        end else begin
          seq_nxt = seq_r + AW'(1);
        end
      end
      ST_FILL: begin
        we = 1'b1;
        wd = blank;
        if (seq_r == LAST_CELL) begin
          seq_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          seq_nxt = seq_r + AW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.cursor_linear = 11'(base_r + AW'(col_r));
          out_item_nxt.cursor_column = 7'(col_r);
          out_item_nxt.cursor_row    = 5'(row_r);
          out_item_nxt.cell_data     = resp_read_r ? rdata_r : 16'h0000;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      seq_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      base_r      <= '0;
      phase_r     <= '0;
      resp_read_r <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_RESET;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      base_r      <= base_nxt;
      phase_r     <= phase_nxt;
      resp_read_r <= resp_read_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // screen memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

endmodule

FILE: design/text_console_writer_top.sv
// ---------------------------------------------------------------------------
// text_console_writer_top
// Text screen console: puts characters at a cursor and reads back cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_item): one transfer per item,
//   either a character to put at the cursor or a cell index to read.
//   Result channel (out_valid / out_stall / out_item): exactly one transfer
//   per input item, in order, giving the cursor and, for reads, the cell.
//   Configuration channel (cfg_valid / cfg_ready / cfg_data): writes the
//   attribute byte; always ready, write only while the block is idle.
//   Path: reads and puts that do not scroll pass through the queue, the
//   execute step and the result register. A put that moves below the
//   last row adds a scroll sweep and a fill of the last row through the
//   screen memory port.
//   Flow: the back end executes one item and registers its result before
//   it takes the next; the two-entry queue absorbs bursts.
//   Reset: the screen memory is cleared one cell a cycle, with in_stall
//   held high; the cursor is homed and the attribute returns to 0x0F.
//   Receiver stall: the result register holds; the back end waits and the
//   queue fills, then in_stall rises.
// ---------------------------------------------------------------------------
module text_console_writer_top #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcw_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tcw_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data
);
  import tcw_pkg::*;

  front_ctl_t  front_ctl;
  queue_stat_t qstat;
  cmd_t        push_cmd;
  logic        push;
  logic        pop;
  logic        queue_full;
  logic        clearing;

  // take configuration writes at any time
  assign cfg_ready = 1'b1;

  assign front_ctl.queue_full = queue_full;
  assign front_ctl.clearing   = clearing;

  // classify and push accepted items
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .ctl      (front_ctl),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouple front from back
  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (queue_full),
    .stat     (qstat)
  );

  // execute commands against the screen and drive results
  tcw_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
